[rtl/xtea_pkg.sv]
`default_nettype none

package xtea_pkg;

    // round constant of the feistel network
    localparam logic [31:0] XTEA_DELTA = 32'h9e37_79b9;

    // key word reset values
    localparam logic [31:0] KEY0_RST = 32'h6c0a_5452;
    localparam logic [31:0] KEY1_RST = 32'h0382_7d0f;
    localparam logic [31:0] KEY2_RST = 32'h3a17_0b92;
    localparam logic [31:0] KEY3_RST = 32'h16db_7fc2;

    // configuration register indexes
    localparam logic [1:0] REG_KEY0 = 2'd0;
    localparam logic [1:0] REG_KEY1 = 2'd1;
    localparam logic [1:0] REG_KEY2 = 2'd2;
    localparam logic [1:0] REG_KEY3 = 2'd3;

    // operation selector
    localparam logic FUNC_ENC = 1'b0;
    localparam logic FUNC_DEC = 1'b1;

    typedef logic [31:0] t_word;

    // shift-xor mix of one half block
    function automatic t_word mix_word(input t_word v);
        mix_word = ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

`default_nettype wire

[rtl/xtea_block_cipher.sv]
`default_nettype none

// XTEA block cipher, 64-bit block, 128-bit key. A block enters on the
// s_axis side as two 32-bit words with the operation in tuser (0 encipher,
// 1 decipher) and leaves on the m_axis side in the same order. Every
// half-round of the network has its own register stage, so the block
// takes one new block per cycle while the skid entry is free. A result
// passes through the stage registers and the output buffer before it is
// presented on m_axis; the depth of one stage is one mix add followed
// by the half-block add or subtract. A two-entry output buffer keeps
// input ready registered and lets the pipeline run while one result
// waits downstream. The user must see that the key words are written
// through the cfg port only while no block is in flight; the block
// itself does not enforce this.
module xtea_block_cipher #(
    parameter int CYCLES = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // config write port
    input  wire                   i_cfg_wr_en,
    input  wire  [1:0]            i_cfg_addr,
    input  wire  [31:0]           i_cfg_wdata,
    // input blocks
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire  [63:0]           s_axis_tdata,   // [31:0] word_first, [63:32] word_second
    input  wire                   s_axis_tuser,   // [0] func
    // result blocks
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    output logic [63:0]           m_axis_tdata    // [31:0] out_first, [63:32] out_second
);

    import xtea_pkg::*;

    localparam int NSTG = 2 * CYCLES;

    // key registers
    t_word r_key [4];

    // pipeline registers
    logic  r_valid [NSTG];
    logic  r_func  [NSTG];
    t_word r_v0    [NSTG];
    t_word r_v1    [NSTG];

    // output register and skid entry
    logic  r_out_valid;
    t_word r_out0;
    t_word r_out1;
    logic  r_skid_valid;
    t_word r_skid0;
    t_word r_skid1;

    logic  w_en;

    // key word writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0] <= KEY0_RST;
            r_key[1] <= KEY1_RST;
            r_key[2] <= KEY2_RST;
            r_key[3] <= KEY3_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_KEY0: r_key[0] <= i_cfg_wdata;
                REG_KEY1: r_key[1] <= i_cfg_wdata;
                REG_KEY2: r_key[2] <= i_cfg_wdata;
                REG_KEY3: r_key[3] <= i_cfg_wdata;
                default:  ;
            endcase
        end
    end

    // pipeline moves whenever the skid entry is free
    assign w_en          = !r_skid_valid;
    assign s_axis_tready = w_en;

    // one half-round per stage
    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        localparam int          HALF    = s % 2;
        localparam int          RND     = s / 2;
        localparam int unsigned ENC_N   = RND + HALF;
        localparam int unsigned DEC_N   = CYCLES - RND - HALF;
        localparam logic [31:0] ENC_SUM = 32'(64'(ENC_N) * 64'(XTEA_DELTA));
        localparam logic [31:0] DEC_SUM = 32'(64'(DEC_N) * 64'(XTEA_DELTA));
        localparam logic [1:0]  ENC_KI  = (HALF == 0) ? ENC_SUM[1:0] : ENC_SUM[12:11];
        localparam logic [1:0]  DEC_KI  = (HALF == 0) ? DEC_SUM[12:11] : DEC_SUM[1:0];

        logic  n_valid;
        logic  n_func;
        t_word n_v0_in;
        t_word n_v1_in;
        logic  n_upd_first;
        t_word n_src;
        t_word n_dst;
        t_word n_key_sum;
        t_word n_tmp;
        t_word n_res;

        // stage input: port for the first stage, previous stage otherwise
        if (s == 0) begin : g_head
            assign n_valid = s_axis_tvalid;
            assign n_func  = s_axis_tuser;
            assign n_v0_in = s_axis_tdata[31:0];
            assign n_v1_in = s_axis_tdata[63:32];
        end else begin : g_body
            assign n_valid = r_valid[s-1];
            assign n_func  = r_func[s-1];
            assign n_v0_in = r_v0[s-1];
            assign n_v1_in = r_v1[s-1];
        end

        // encipher updates the first word on even stages, decipher the second
        always_comb begin
            n_upd_first = (n_func == FUNC_DEC) ? (HALF == 1) : (HALF == 0);
            n_src       = n_upd_first ? n_v1_in : n_v0_in;
            n_dst       = n_upd_first ? n_v0_in : n_v1_in;
            n_key_sum   = (n_func == FUNC_DEC) ? (DEC_SUM + r_key[DEC_KI])
                                               : (ENC_SUM + r_key[ENC_KI]);
            n_tmp       = mix_word(n_src) ^ n_key_sum;
            n_res       = (n_func == FUNC_DEC) ? (n_dst - n_tmp) : (n_dst + n_tmp);
        end

        // stage valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (w_en) begin
                r_valid[s] <= (s == 0) ? (s_axis_tvalid && s_axis_tready) : n_valid;
            end
        end

        // stage payload
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_func[s] <= n_func;
                r_v0[s]   <= n_upd_first ? n_res : n_v0_in;
                r_v1[s]   <= n_upd_first ? n_v1_in : n_res;
            end
        end
    end

    // output register with skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (r_valid[NSTG-1]) begin
            if (!r_out_valid || m_axis_tready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output and skid payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out0 <= r_skid0;
                r_out1 <= r_skid1;
            end
        end else if (r_valid[NSTG-1]) begin
            if (!r_out_valid || m_axis_tready) begin
                r_out0 <= r_v0[NSTG-1];
                r_out1 <= r_v1[NSTG-1];
            end else begin
                r_skid0 <= r_v0[NSTG-1];
                r_skid1 <= r_v1[NSTG-1];
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out1, r_out0};

endmodule

`default_nettype wire

[tb/xtea_block_cipher_checker.sv]
`timescale 1ns / 1ps

module xtea_block_cipher_checker #(
    parameter int ROUNDS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // key register writes
    input  wire         i_cfg_wr_en,
    input  wire  [1:0]  i_cfg_addr,
    input  wire  [31:0] i_cfg_wdata,
    // input block channel
    input  wire         i_in_valid,
    input  wire         i_in_ready,
    input  wire  [63:0] i_in_data,    // [31:0] word_first, [63:32] word_second
    input  wire         i_in_func,    // [0] func
    // result block channel
    input  wire         i_out_valid,
    input  wire         i_out_ready,
    input  wire  [63:0] i_out_data,   // [31:0] out_first, [63:32] out_second
    output logic [31:0] o_fail_count,
    output logic [31:0] o_pending
);

    import xtea_pkg::*;

    typedef struct packed {
        logic [31:0] second;
        logic [31:0] first;
    } t_block;

    // shadow copy of the key registers
    logic [31:0] key_q [4];
    t_block      expected_blocks [$];
    int          fail_count    = 0;
    int          pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    task automatic report_error(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic logic [31:0] shift_mix(input logic [31:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

    // forward network, round sum counts up from zero
    function automatic t_block encipher_block(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] v0, v1, sum;
        t_block      r;
        int          i;
        v0  = a;
        v1  = b;
        sum = '0;
        for (i = 0; i < ROUNDS; i++) begin
            v0  = v0 + (shift_mix(v1) ^ (sum + key_q[sum[1:0]]));
            sum = sum + XTEA_DELTA;
            v1  = v1 + (shift_mix(v0) ^ (sum + key_q[sum[12:11]]));
        end
        r.first  = v0;
        r.second = v1;
        return r;
    endfunction

    // inverse network, round sum counts down from delta times rounds
    function automatic t_block decipher_block(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] v0, v1, sum;
        t_block      r;
        int          i;
        v0  = a;
        v1  = b;
        sum = XTEA_DELTA * 32'(ROUNDS);
        for (i = 0; i < ROUNDS; i++) begin
            v1  = v1 - (shift_mix(v0) ^ (sum + key_q[sum[12:11]]));
            sum = sum - XTEA_DELTA;
            v0  = v0 - (shift_mix(v1) ^ (sum + key_q[sum[1:0]]));
        end
        r.first  = v0;
        r.second = v1;
        return r;
    endfunction

    // watch all channels at each rising edge
    always @(posedge i_clk) begin : watch
        t_block got, want;
        if (!i_rst_n) begin
            key_q[REG_KEY0] = KEY0_RST;
            key_q[REG_KEY1] = KEY1_RST;
            key_q[REG_KEY2] = KEY2_RST;
            key_q[REG_KEY3] = KEY3_RST;
            expected_blocks.delete();
        end else begin
            // result beat against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (expected_blocks.size() == 0) begin
                    report_error($sformatf("result %h with nothing outstanding", got));
                end else begin
                    want = expected_blocks.pop_front();
                    if (got.first !== want.first)
                        report_error($sformatf("out_first expected %h, got %h",
                                               want.first, got.first));
                    if (got.second !== want.second)
                        report_error($sformatf("out_second expected %h, got %h",
                                               want.second, got.second));
                end
            end
            // input beat, predicted with the keys in force now
            if (i_in_valid && i_in_ready) begin
                if (i_in_func == FUNC_DEC)
                    expected_blocks.push_back(decipher_block(i_in_data[31:0], i_in_data[63:32]));
                else
                    expected_blocks.push_back(encipher_block(i_in_data[31:0], i_in_data[63:32]));
            end
            if (i_cfg_wr_en)
                key_q[i_cfg_addr] = i_cfg_wdata;
        end
        pending_count = expected_blocks.size();
    end

endmodule

[tb/xtea_block_cipher_tb.sv]
`timescale 1ns / 1ps

module xtea_block_cipher_tb;

    import xtea_pkg::*;

    // pipeline plus output buffer, with margin
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 200;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr  = REG_KEY0;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid  = 1'b0;
    logic [63:0] in_data   = '0;
    logic        in_func   = FUNC_ENC;
    logic        out_ready = 1'b0;
    wire         in_ready;
    wire         out_valid;
    wire  [63:0] out_data;
    wire  [31:0] fail_count;
    wire  [31:0] pending;

    // sender and receiver pacing controls
    bit gapless    = 1'b0;
    bit rx_steady  = 1'b0;
    bit hold_req   = 1'b0;
    int burst_left = 0;

    xtea_block_cipher dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (in_ready),
        .s_axis_tdata  (in_data),
        .s_axis_tuser  (in_func),
        .m_axis_tvalid (out_valid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (out_data)
    );

    xtea_block_cipher_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_in_func    (in_func),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        forever #4 clk = ~clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // receiver: ready runs broken by short stalls, one long hold-off on request
    initial begin : receiver
        int n;
        forever begin
            if (hold_req) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end else if (rx_steady) begin
                @(negedge clk);
                out_ready <= 1'b1;
            end else begin
                n = $urandom_range(1, 40);
                @(negedge clk);
                out_ready <= 1'b1;
                repeat (n - 1) @(negedge clk);
                n = $urandom_range(0, 6);
                if (n > 0) begin
                    @(negedge clk);
                    out_ready <= 1'b0;
                    repeat (n - 1) @(negedge clk);
                end
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 19))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h0000_0001;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // offer one block and hold it until the beat is taken
    task automatic send_block(input logic func, input logic [31:0] a, input logic [31:0] b);
        @(negedge clk);
        in_valid <= 1'b1;
        in_func  <= func;
        in_data  <= {b, a};
        do @(posedge clk); while (!in_ready);
    endtask

    // burst bookkeeping between beats
    task automatic pace();
        int gap;
        if (gapless)
            return;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [31:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
    endtask

    task automatic load_keys(input logic [31:0] k0, input logic [31:0] k1,
                             input logic [31:0] k2, input logic [31:0] k3);
        drain();
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            send_block(1'($urandom_range(0, 1)), pick_word(), pick_word());
            pace();
        end
    endtask

    // stimulus
    initial begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // directed blocks under the reset key
        send_block(FUNC_ENC, 32'h0000_0000, 32'h0000_0000);
        send_block(FUNC_ENC, 32'hffff_ffff, 32'hffff_ffff);
        send_block(FUNC_DEC, 32'h0000_0000, 32'h0000_0000);
        send_block(FUNC_DEC, 32'hffff_ffff, 32'hffff_ffff);
        send_block(FUNC_ENC, 32'h0000_0000, 32'hffff_ffff);
        send_block(FUNC_DEC, 32'hffff_ffff, 32'h0000_0000);
        send_block(FUNC_ENC, 32'haaaa_aaaa, 32'h5555_5555);
        send_block(FUNC_DEC, 32'h5555_5555, 32'haaaa_aaaa);
        send_block(FUNC_ENC, 32'h0000_0001, 32'h8000_0000);
        send_block(FUNC_DEC, 32'h8000_0000, 32'h0000_0001);
        send_block(FUNC_ENC, 32'h0123_4567, 32'h89ab_cdef);
        send_block(FUNC_DEC, 32'h0123_4567, 32'h89ab_cdef);
        run_random(PHASE_ITEMS);

        // all-zero key
        load_keys(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_block(FUNC_ENC, 32'h0000_0000, 32'h0000_0000);
        send_block(FUNC_DEC, 32'h0000_0000, 32'h0000_0000);
        run_random(PHASE_ITEMS);

        // all-ones key, receiver holds off while the sender keeps offering
        load_keys(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        gapless  = 1'b1;
        hold_req = 1'b1;
        run_random(PHASE_ITEMS);
        gapless  = 1'b0;

        // random key at full rate on both sides
        load_keys($urandom, $urandom, $urandom, $urandom);
        gapless   = 1'b1;
        rx_steady = 1'b1;
        run_random(PHASE_ITEMS);
        gapless   = 1'b0;
        rx_steady = 1'b0;

        // mixed extremes across the key words
        load_keys(32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000);
        run_random(PHASE_ITEMS);

        // random key, sender pauses mid-phase until all results are back
        load_keys($urandom, $urandom, $urandom, $urandom);
        run_random(PHASE_ITEMS / 2);
        drain();
        run_random(PHASE_ITEMS / 2);

        load_keys($urandom, $urandom, $urandom, $urandom);
        run_random(PHASE_ITEMS);

        // back to the reset key values
        load_keys(KEY0_RST, KEY1_RST, KEY2_RST, KEY3_RST);
        run_random(PHASE_ITEMS);

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
rtl/xtea_pkg.sv
rtl/xtea_block_cipher.sv
tb/xtea_block_cipher_checker.sv
tb/xtea_block_cipher_tb.sv
